// ----- design/min_degree_vertex_eliminator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the minimum-degree vertex eliminator
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_DEGREE_VERTEX_ELIMINATOR_ASSERT_SVH
`define MIN_DEGREE_VERTEX_ELIMINATOR_ASSERT_SVH

// Checks that a property holds at every rising edge outside reset.
`define MDVE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition implies another in the following cycle.
`define MDVE_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ----- design/mdve_pkg.sv -----
// ----------------------------------------------------------------------------
// Minimum-degree vertex eliminator package
// Sizes, request and error codes and the controller state type.
// ----------------------------------------------------------------------------
package mdve_pkg;

  localparam int MaxVertices = 64;
  localparam int SlotW       = $clog2(MaxVertices);
  localparam int CountW      = SlotW + 1;
  localparam int PairW       = 11;

  typedef logic [MaxVertices-1:0] row_t;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_WRITE  = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_QUERY  = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_RANGE = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

// ----- design/min_degree_vertex_eliminator.sv -----
// ----------------------------------------------------------------------------
// Minimum-degree vertex eliminator
// Graph store as a ring of row cells with a walking controller.
// ----------------------------------------------------------------------------
// Channel | Signals                           | Direction
// s       | s_tvalid s_tready s_tdata s_tuser | request items in
// m       | m_tvalid m_tready m_tdata m_tuser | result items out
//
// A clear, a valid pair write, a find, a remove or a query walks the graph:
// the ring of 64 row cells turns once past the head, one row per cycle.
// Rejected and unknown requests give their result in the cycle after they are taken.
// Reset clears the matrix, the live mask and all counts at once.
// One item is in work at a time; a waiting result holds off the next item.
// ----------------------------------------------------------------------------
module min_degree_vertex_eliminator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // vertex_total[6:0], row_index[12:7], col_index[18:13], edge_bit[19],
  // position[25:20]
  input  logic [31:0] s_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found_position[5:0], degree[11:6], live_count[18:12], complete[19]
  output logic [23:0] m_tdata,
  // error[1:0]
  output logic [1:0]  m_tuser
);
  import mdve_pkg::*;

  row_t rows [MaxVertices];
  row_t head_new;
  logic shift;

  state_t state, state_next;
  logic [SlotW-1:0]  slot;
  logic [CountW-1:0] seen;
  logic [2:0]        req;
  logic [SlotW-1:0]  row_l, col_l, pos_l;
  logic              edge_l;
  row_t              live_mask;
  logic [CountW-1:0] vertex_count, live_cnt;
  logic [PairW-1:0]  spc, pairs_max;
  logic              complete_flag;
  logic [CountW-1:0] best_deg;
  logic [SlotW-1:0]  best_pos;
  logic              have;

  logic              accept;
  logic [CountW-1:0] total, n_sat, head_deg;
  logic [2*CountW-1:0] prod;
  logic [SlotW-1:0]  d_row, d_col, d_pos;
  logic              bad_pair, is_live, hit;
  logic [SlotW-1:0]  deg_sat;

  genvar gi;
  generate
    for (gi = 0; gi < MaxVertices; gi++) begin : g_cell
      if (gi == MaxVertices - 1) begin : g_tail
        mdve_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(head_new), .q(rows[gi]));
      end else begin : g_body
        mdve_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(rows[gi+1]), .q(rows[gi]));
      end
    end
  endgenerate

  assign total    = s_tdata[6:0];
  assign d_row    = s_tdata[12:7];
  assign d_col    = s_tdata[18:13];
  assign d_pos    = s_tdata[25:20];
  assign n_sat    = (total > CountW'(MaxVertices)) ? CountW'(MaxVertices) : total;
  assign prod     = n_sat * (n_sat - CountW'(1));
  assign bad_pair = !((d_row < d_col) && ({1'b0, d_col} < vertex_count));
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !m_tvalid;
  assign shift    = (state == ST_WALK);
  assign is_live  = live_mask[slot];
  assign head_deg = CountW'($countones(rows[0] & live_mask));
  assign hit      = is_live && (seen == {1'b0, pos_l});

  always_comb begin
    head_new = rows[0];
    if (req == REQ_CLEAR) begin
      head_new = '0;
    end else if (req == REQ_WRITE) begin
      if (slot == row_l) head_new[col_l] = edge_l;
      if (slot == col_l) head_new[row_l] = edge_l;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (s_tuser inside {REQ_CLEAR, REQ_WRITE, REQ_FIND, REQ_REMOVE,
                                       REQ_QUERY})) begin
          if (s_tuser == REQ_CLEAR) state_next = ST_WALK;
          else if (s_tuser == REQ_WRITE) state_next = bad_pair ? ST_IDLE : ST_WALK;
          else if (live_cnt == '0) state_next = ST_IDLE;
          else if (s_tuser == REQ_FIND) state_next = ST_WALK;
          else if ({1'b0, d_pos} >= live_cnt) state_next = ST_IDLE;
          else state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (slot == SlotW'(MaxVertices - 1)) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign deg_sat = (best_deg > CountW'(63)) ? SlotW'(63) : best_deg[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      live_mask     <= '0;
      vertex_count  <= '0;
      live_cnt      <= '0;
      spc           <= '0;
      pairs_max     <= '0;
      complete_flag <= 1'b0;
      slot          <= '0;
      seen          <= '0;
      have          <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req      <= s_tuser;
            row_l    <= d_row;
            col_l    <= d_col;
            edge_l   <= s_tdata[19];
            pos_l    <= d_pos;
            slot     <= '0;
            seen     <= '0;
            have     <= 1'b0;
            best_deg <= '0;
            best_pos <= '0;
            if (state_next == ST_IDLE) begin
              m_tvalid      <= 1'b1;
              m_tdata[11:0] <= '0;
              m_tdata[18:12] <= live_cnt;
              m_tdata[19]   <= complete_flag;
              m_tdata[23:20] <= '0;
              if (!(s_tuser inside {REQ_CLEAR, REQ_WRITE, REQ_FIND, REQ_REMOVE,
                                    REQ_QUERY})) m_tuser <= ERR_OK;
              else if (s_tuser == REQ_WRITE) m_tuser <= ERR_RANGE;
              else if (live_cnt == '0) m_tuser <= ERR_EMPTY;
              else m_tuser <= ERR_RANGE;
            end
            if (s_tuser == REQ_CLEAR) begin
              for (int i = 0; i < MaxVertices; i++) begin
                live_mask[i] <= (CountW'(i) < n_sat);
              end
              vertex_count  <= n_sat;
              live_cnt      <= n_sat;
              spc           <= '0;
              pairs_max     <= PairW'(prod >> 1);
              complete_flag <= (n_sat <= CountW'(1));
            end
          end
        end
        ST_WALK: begin
          slot <= slot + SlotW'(1);
          if (is_live) seen <= seen + CountW'(1);
          case (req)
            REQ_WRITE: begin
              if ((slot == row_l) && (rows[0][col_l] != edge_l)) begin
                spc <= edge_l ? spc + PairW'(1) : spc - PairW'(1);
              end
            end
            REQ_FIND: begin
              if (is_live && (!have || head_deg < best_deg)) begin
                best_deg <= head_deg;
                best_pos <= seen[SlotW-1:0];
                have     <= 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (hit) begin
                live_mask[slot] <= 1'b0;
                live_cnt        <= live_cnt - CountW'(1);
              end
            end
            REQ_QUERY: begin
              if (hit) best_deg <= head_deg;
            end
            default: ;
          endcase
        end
        ST_DONE: begin
          m_tvalid       <= 1'b1;
          m_tuser        <= ERR_OK;
          m_tdata[18:12] <= live_cnt;
          m_tdata[23:20] <= '0;
          case (req)
            REQ_WRITE: begin
              m_tdata[19]   <= (spc == pairs_max);
              m_tdata[11:0] <= '0;
              complete_flag <= (spc == pairs_max);
            end
            REQ_FIND: begin
              m_tdata[19]   <= complete_flag;
              m_tdata[11:0] <= {deg_sat, best_pos};
            end
            REQ_REMOVE: begin
              m_tdata[19]   <= complete_flag;
              m_tdata[11:0] <= {SlotW'(0), pos_l};
            end
            REQ_QUERY: begin
              m_tdata[19]   <= complete_flag;
              m_tdata[11:0] <= {deg_sat, pos_l};
            end
            default: begin
              m_tdata[19]   <= complete_flag;
              m_tdata[11:0] <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

`include "min_degree_vertex_eliminator_assert.svh"

  `MDVE_ASSERT(a_no_accept_busy, (state != ST_IDLE) |-> !s_tready, "item accepted while busy")
  `MDVE_ASSERT(a_live_count, CountW'($countones(live_mask)) == live_cnt, "live count drift")
  `MDVE_ASSERT_NEXT(a_walk_end, (state == ST_WALK) && (slot == SlotW'(MaxVertices - 1)), (state == ST_DONE) && m_tvalid == 1'b0, "walk did not finish")

endmodule

// ----- design/mdve_cell.sv -----
// ----------------------------------------------------------------------------
// Adjacency row cell
// Holds one matrix row and takes its neighbour's row on every shift.
// ----------------------------------------------------------------------------
module mdve_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  mdve_pkg::row_t d,
  output mdve_pkg::row_t q
);
  import mdve_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

// ----- sim/min_degree_vertex_eliminator_tb.sv -----
// ----------------------------------------------------------------------------
// Minimum-degree vertex eliminator testbench
// Drives request items through the stream port, predicts each result item from
// a local graph copy or a fixed table row and compares every field. Directed
// rows run first, then random graph sessions with random idling on both sides.
// ----------------------------------------------------------------------------
module min_degree_vertex_eliminator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mdve_pkg::*;

  typedef struct packed {
    logic [5:0] position;
    logic       edge_bit;
    logic [5:0] col_index;
    logic [5:0] row_index;
    logic [6:0] vertex_total;
  } req_fields_t;

  typedef struct {
    logic [2:0]  kind;
    req_fields_t f;
  } req_item_t;

  typedef struct {
    logic [5:0] found_position;
    logic [5:0] degree;
    logic [6:0] live_count;
    logic       complete;
    logic [1:0] error;
  } res_item_t;

  typedef struct {
    req_item_t req;
    logic      fixed;
    res_item_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  row_t       adj [MaxVertices];
  row_t       live_bits;
  int         vcount;
  int         pair_count;
  logic       full_flag;
  res_item_t  pending_results [$];
  int         mismatches = 0;
  bit         quiet = 1'b0;
  bit         hold_long = 1'b0;
  dir_row_t   dir_rows [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  min_degree_vertex_eliminator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic int slot_of(int pos);
    int seen;
    seen = 0;
    for (int s = 0; s < MaxVertices; s++) begin
      if (live_bits[s]) begin
        if (seen == pos) return s;
        seen++;
      end
    end
    return 0;
  endfunction

  function automatic res_item_t eliminate_step(req_item_t r);
    res_item_t o;
    int live, n, d, p, s, row, col;
    bit have;
    o = '{default: '0};
    live = $countones(live_bits);
    row = r.f.row_index;
    col = r.f.col_index;
    if (r.kind == REQ_CLEAR) begin
      n = (r.f.vertex_total > MaxVertices) ? MaxVertices : r.f.vertex_total;
      foreach (adj[i]) adj[i] = '0;
      live_bits = '0;
      for (int i = 0; i < n; i++) live_bits[i] = 1'b1;
      vcount = n;
      pair_count = 0;
      full_flag = (n <= 1);
      live = n;
    end else if (r.kind == REQ_WRITE) begin
      if (row < col && col < vcount) begin
        if (adj[row][col] != r.f.edge_bit) pair_count += r.f.edge_bit ? 1 : -1;
        adj[row][col] = r.f.edge_bit;
        adj[col][row] = r.f.edge_bit;
        full_flag = (pair_count == vcount * (vcount - 1) / 2);
      end else o.error = ERR_RANGE;
    end else if (r.kind inside {REQ_FIND, REQ_REMOVE, REQ_QUERY}) begin
      if (live == 0) o.error = ERR_EMPTY;
      else if (r.kind == REQ_FIND) begin
        have = 0;
        p = 0;
        for (s = 0; s < MaxVertices; s++) begin
          if (live_bits[s]) begin
            d = $countones(adj[s] & live_bits);
            if (!have || d < o.degree) begin
              o.degree = 6'((d > 63) ? 63 : d);
              o.found_position = 6'(p);
              have = 1;
            end
            p++;
          end
        end
      end else if (r.f.position >= live) o.error = ERR_RANGE;
      else begin
        s = slot_of(r.f.position);
        o.found_position = r.f.position;
        if (r.kind == REQ_REMOVE) begin
          live_bits[s] = 1'b0;
          live--;
        end else begin
          d = $countones(adj[s] & live_bits);
          o.degree = 6'((d > 63) ? 63 : d);
        end
      end
    end
    o.live_count = 7'(live);
    o.complete = full_flag;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic req_item_t make_req(logic [2:0] k, int total, int row, int col,
                                         int e, int pos);
    req_item_t r;
    r.kind = k;
    r.f.vertex_total = 7'(total);
    r.f.row_index = 6'(row);
    r.f.col_index = 6'(col);
    r.f.edge_bit = 1'(e);
    r.f.position = 6'(pos);
    return r;
  endfunction

  task automatic send_item(req_item_t r, bit fixed, res_item_t want);
    res_item_t pred;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= r.kind;
    s_tdata <= {6'b0, r.f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = eliminate_step(r);
    pending_results.push_back(fixed ? want : pred);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    res_item_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        w = pending_results.pop_front();
        if (m_tdata[5:0] != w.found_position)
          report_mismatch("found_position", m_tdata[5:0], w.found_position);
        if (m_tdata[11:6] != w.degree) report_mismatch("degree", m_tdata[11:6], w.degree);
        if (m_tdata[18:12] != w.live_count)
          report_mismatch("live_count", m_tdata[18:12], w.live_count);
        if (m_tdata[19] != w.complete) report_mismatch("complete", m_tdata[19], w.complete);
        if (m_tuser != w.error) report_mismatch("error", m_tuser, w.error);
      end
    end
  end

  initial begin
    int gap;
    @(negedge clk);
    forever begin
      if (hold_long) begin
        m_tready <= 1'b0;
        for (int c = 0; c < 400; c++) @(negedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        gap = $urandom_range(1, 11);
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  end

  initial begin
    #40ms;
    $display("min_degree_vertex_eliminator_tb: done, errors");
    $finish;
  end

  initial begin
    req_item_t r;
    res_item_t z;
    int n, sent, remaining;
    foreach (adj[i]) adj[i] = '0;
    live_bits = '0;
    vcount = 0;
    pair_count = 0;
    full_flag = 1'b0;
    z = '{default: '0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir_rows.push_back('{make_req(REQ_FIND, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, ERR_EMPTY}});
    dir_rows.push_back('{make_req(REQ_REMOVE, 0, 0, 0, 0, 63), 1, '{0, 0, 0, 0, ERR_EMPTY}});
    dir_rows.push_back('{make_req(REQ_QUERY, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 0, ERR_EMPTY}});
    dir_rows.push_back('{make_req(REQ_CLEAR, 1, 0, 0, 0, 0), 1, '{0, 0, 1, 1, ERR_OK}});
    dir_rows.push_back('{make_req(REQ_CLEAR, 127, 0, 0, 0, 0), 1, '{0, 0, 64, 0, ERR_OK}});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 0, 63, 1, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 63, 0, 1, 0), 1, '{0, 0, 64, 0, ERR_RANGE}});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 5, 5, 1, 0), 1, '{0, 0, 64, 0, ERR_RANGE}});
    dir_rows.push_back('{make_req(REQ_QUERY, 0, 0, 0, 0, 63), 0, z});
    dir_rows.push_back('{make_req(REQ_FIND, 0, 0, 0, 0, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_REMOVE, 0, 0, 0, 0, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_QUERY, 0, 0, 0, 0, 63), 1, '{0, 0, 63, 0, ERR_RANGE}});
    dir_rows.push_back('{make_req(3'd5, 127, 63, 63, 1, 63), 0, z});
    dir_rows.push_back('{make_req(3'd7, 0, 0, 0, 0, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_CLEAR, 3, 0, 0, 0, 0), 1, '{0, 0, 3, 0, ERR_OK}});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 0, 1, 1, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 0, 2, 1, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 1, 2, 1, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_REMOVE, 0, 0, 0, 0, 1), 0, z});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 1, 2, 0, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_FIND, 0, 0, 0, 0, 0), 0, z});
    dir_rows.push_back('{make_req(REQ_CLEAR, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1, ERR_OK}});
    dir_rows.push_back('{make_req(REQ_WRITE, 0, 0, 1, 1, 0), 1, '{0, 0, 0, 1, ERR_RANGE}});
    foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].res);

    sent = 0;
    while (sent < 1100) begin
      if (sent > 950) quiet = 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 10);
      send_item(make_req(REQ_CLEAR, n, $urandom, $urandom, $urandom, $urandom), 0, z);
      sent++;
      if (sent > 300 && sent < 340) hold_long = 1'b1;
      for (int k = 0; k < $urandom_range(6, 30); k++) begin
        remaining = vcount < 2 ? 2 : vcount;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: r = make_req(REQ_WRITE, $urandom, $urandom_range(0, remaining - 2),
                                   $urandom_range(1, remaining - 1), $urandom, $urandom);
          4: r = make_req(REQ_FIND, $urandom, $urandom, $urandom, $urandom, $urandom);
          5, 6: r = make_req(REQ_REMOVE, $urandom, $urandom, $urandom, $urandom,
                             $urandom_range(0, remaining));
          7: r = make_req(REQ_QUERY, $urandom, $urandom, $urandom, $urandom,
                          $urandom_range(0, remaining));
          default: r = make_req($urandom_range(0, 7), $urandom, $urandom, $urandom,
                                $urandom, $urandom);
        endcase
        if (r.kind == REQ_CLEAR) r.f.vertex_total = 7'($urandom_range(0, 12));
        send_item(r, 0, z);
        sent++;
      end
    end
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("min_degree_vertex_eliminator_tb: done, clean");
    end else begin
      $display("min_degree_vertex_eliminator_tb: done, errors");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/mdve_pkg.sv
design/mdve_cell.sv
design/min_degree_vertex_eliminator.sv
sim/min_degree_vertex_eliminator_tb.sv
